### design/dmxrdm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmxrdm_pkg
// Shared types and constants of the DMX512 / RDM frame receiver.
// ----------------------------------------------------------------------------
package dmxrdm_pkg;

	// field widths fixed by the interface
	localparam int SLOT_W = 10;
	localparam int TIME_W = 32;
	localparam int MIN_W  = 10;

	// default sizes
	localparam int UNIVERSE_SLOTS_DEF   = 512;
	localparam int RDM_BUFFER_BYTES_DEF = 512;

	// discovery response layout
	localparam int UID_BYTES     = 6;
	localparam int EUID_BYTES    = 2 * UID_BYTES;
	localparam int DISC_CS_BYTES = 4;
	localparam int PREAMBLE_END  = 9;

	// register reset
	localparam logic [MIN_W-1:0] MIN_SLOT_RESET = 10'd44;

	// start codes and markers
	localparam logic [7:0] SC_DMX     = 8'h00;
	localparam logic [7:0] SC_RDM     = 8'hCC;
	localparam logic [7:0] DISC_PRE   = 8'hFE;
	localparam logic [7:0] DISC_SEP   = 8'hAA;
	localparam logic [7:0] RDM_SUB_SC = 8'h01;

	// command codes
	localparam logic CMD_CHAR = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	// packet kinds
	localparam logic [1:0] KIND_NONE = 2'd0;
	localparam logic [1:0] KIND_DMX  = 2'd1;
	localparam logic [1:0] KIND_RDM  = 2'd2;
	localparam logic [1:0] KIND_DISC = 2'd3;

	// packet events
	localparam logic [1:0] EV_NONE     = 2'd0;
	localparam logic [1:0] EV_GOOD     = 2'd1;
	localparam logic [1:0] EV_REJECT   = 2'd2;
	localparam logic [1:0] EV_OVERFLOW = 2'd3;

	typedef struct packed {
		logic              cmd;
		logic [7:0]        rx_byte;
		logic              is_break;
		logic [TIME_W-1:0] time_us;
	} in_item_t;

	typedef struct packed {
		logic [1:0]        packet_kind;
		logic              byte_valid;
		logic [SLOT_W-1:0] slot_index;
		logic [7:0]        slot_byte;
		logic [1:0]        packet_event;
		logic [SLOT_W-1:0] dmx_slot_count;
		logic [TIME_W-1:0] slot_time_us;
		logic [TIME_W-1:0] break_to_break_us;
		logic              break_to_break_valid;
	} out_item_t;

endpackage

### design/dmx_rdm_frame_receiver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmx_rdm_frame_receiver
// DMX512 / RDM frame receiver: parses timestamped UART characters and ticks.
//
// Input channel (in_valid / in_stall / in_data): one UART character, a byte
// or a break, with its microsecond timestamp, or a timer tick. Output channel
// (out_valid / out_stall / out_data): the stored slot byte with its index,
// packet kind and events (DMX complete, RDM checksum result or overflow,
// discovery response complete), slot time and break-to-break time.
// A transfer may cause no result (breaks, ignored bytes, quiet ticks).
// Throughput is one transfer per cycle while in_stall is low; each result is
// registered on its way to the output. The frame state is updated by one
// pass of logic per transfer, and the result register plus one skid entry
// decouple the sides: in_stall rises only when both hold an undelivered result.
// cfg_wr_en / cfg_wr_data set the slot time floor (reset 44 us); write it
// while the block is idle. Reset puts the receiver in the idle phase with
// all timestamps and history cleared and drops any pending result.
// ----------------------------------------------------------------------------
module dmx_rdm_frame_receiver #(
	parameter int UNIVERSE_SLOTS   = dmxrdm_pkg::UNIVERSE_SLOTS_DEF,
	parameter int RDM_BUFFER_BYTES = dmxrdm_pkg::RDM_BUFFER_BYTES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  dmxrdm_pkg::in_item_t         in_data,
	output logic                         out_valid,
	input  logic                         out_stall,
	output dmxrdm_pkg::out_item_t        out_data,
	input  logic                         cfg_wr_en,
	input  logic [dmxrdm_pkg::MIN_W-1:0] cfg_wr_data
);
	import dmxrdm_pkg::*;

	logic      fire;
	logic      res_valid;
	out_item_t res;
	logic      full;

	// input transfer
	assign fire     = in_valid & ~full;
	assign in_stall = full;

	dmxrdm_parser #(
		.UNIVERSE_SLOTS   (UNIVERSE_SLOTS),
		.RDM_BUFFER_BYTES (RDM_BUFFER_BYTES)
	) u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (fire),
		.item        (in_data),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.res_valid   (res_valid),
		.res         (res)
	);

	dmxrdm_out_skid u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (fire & res_valid),
		.push_data (res),
		.full      (full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

### design/dmxrdm_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmxrdm_parser
// Frame state machine: decodes one character or tick per transfer and
// produces at most one result item.
// ----------------------------------------------------------------------------
module dmxrdm_parser #(
	parameter int UNIVERSE_SLOTS   = dmxrdm_pkg::UNIVERSE_SLOTS_DEF,
	parameter int RDM_BUFFER_BYTES = dmxrdm_pkg::RDM_BUFFER_BYTES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         fire,
	input  dmxrdm_pkg::in_item_t         item,
	input  logic                         cfg_wr_en,
	input  logic [dmxrdm_pkg::MIN_W-1:0] cfg_wr_data,
	output logic                         res_valid,
	output dmxrdm_pkg::out_item_t        res
);
	import dmxrdm_pkg::*;

	localparam int MAX_POS = (RDM_BUFFER_BYTES > UNIVERSE_SLOTS + 1) ?
		RDM_BUFFER_BYTES : UNIVERSE_SLOTS + 1;
	localparam int POS_W = $clog2(MAX_POS + 1);

	// phase codes
	localparam logic [3:0] PH_IDLE  = 4'd0;
	localparam logic [3:0] PH_BREAK = 4'd1;
	localparam logic [3:0] PH_DMX   = 4'd2;
	localparam logic [3:0] PH_RDM   = 4'd3;
	localparam logic [3:0] PH_CSH   = 4'd4;
	localparam logic [3:0] PH_CSL   = 4'd5;
	localparam logic [3:0] PH_DFE   = 4'd6;
	localparam logic [3:0] PH_EUID  = 4'd7;
	localparam logic [3:0] PH_ECS   = 4'd8;

	logic [MIN_W-1:0]  min_slot_q;
	logic [3:0]        phase_q,      phase_d;
	logic [POS_W-1:0]  pos_q,        pos_d;
	logic [4:0]        disc_cnt_q,   disc_cnt_d;
	logic [15:0]       rdm_sum_q,    rdm_sum_d;
	logic [7:0]        rdm_len_q,    rdm_len_d;
	logic [7:0]        rdm_sub_q,    rdm_sub_d;
	logic [TIME_W-1:0] last_time_q,  last_time_d;
	logic [TIME_W-1:0] slot_time_q,  slot_time_d;
	logic [TIME_W-1:0] brk_latest_q, brk_latest_d;
	logic [TIME_W-1:0] brk_prev_q,   brk_prev_d;
	logic              prev_dmx_q,   prev_dmx_d;

	logic [POS_W-1:0]  pos_inc;
	logic [TIME_W-1:0] elapsed;
	logic [TIME_W-1:0] floored;
	logic [15:0]       sum_add;
	logic [15:0]       sum_csl;
	logic [4:0]        disc_inc;

	assign pos_inc  = pos_q + 1'b1;
	assign elapsed  = item.time_us - last_time_q;
	assign floored  = (elapsed < TIME_W'(min_slot_q)) ? TIME_W'(min_slot_q) : elapsed;
	assign sum_add  = rdm_sum_q + {8'h00, item.rx_byte};
	assign sum_csl  = rdm_sum_q - {8'h00, item.rx_byte};
	assign disc_inc = disc_cnt_q + 1'b1;

	// next state and result for the item on the input
	always_comb begin
		phase_d      = phase_q;
		pos_d        = pos_q;
		disc_cnt_d   = disc_cnt_q;
		rdm_sum_d    = rdm_sum_q;
		rdm_len_d    = rdm_len_q;
		rdm_sub_d    = rdm_sub_q;
		last_time_d  = last_time_q;
		slot_time_d  = slot_time_q;
		brk_latest_d = brk_latest_q;
		brk_prev_d   = brk_prev_q;
		prev_dmx_d   = prev_dmx_q;
		res_valid    = 1'b0;
		res          = '0;
		if (item.cmd == CMD_TICK) begin
			// slot timeout closes a dmx packet
			if (phase_q == PH_DMX && elapsed > slot_time_q) begin
				phase_d            = PH_IDLE;
				res_valid          = 1'b1;
				res.packet_kind    = KIND_DMX;
				res.packet_event   = EV_GOOD;
				res.dmx_slot_count = SLOT_W'(pos_q - 1'b1);
				res.slot_time_us   = slot_time_q;
			end
		end else if (item.is_break) begin
			phase_d      = PH_BREAK;
			brk_latest_d = item.time_us;
			last_time_d  = item.time_us;
		end else begin
			last_time_d    = item.time_us;
			res.slot_byte  = item.rx_byte;
			res.slot_index = SLOT_W'(pos_q);
			case (phase_q)
				PH_IDLE: begin
					if (item.rx_byte == DISC_PRE) begin
						phase_d         = PH_DFE;
						pos_d           = POS_W'(1);
						res_valid       = 1'b1;
						res.packet_kind = KIND_DISC;
						res.byte_valid  = 1'b1;
						res.slot_index  = '0;
					end
				end
				PH_BREAK: begin
					res.slot_index = '0;
					if (item.rx_byte == SC_DMX) begin
						// break to break time only when the last break was dmx too
						if (prev_dmx_q) begin
							res.break_to_break_us    = brk_latest_q - brk_prev_q;
							res.break_to_break_valid = 1'b1;
						end
						prev_dmx_d       = 1'b1;
						brk_prev_d       = brk_latest_q;
						phase_d          = PH_DMX;
						pos_d            = POS_W'(1);
						res_valid        = 1'b1;
						res.packet_kind  = KIND_DMX;
						res.byte_valid   = 1'b1;
						res.slot_time_us = slot_time_q;
					end else if (item.rx_byte == SC_RDM) begin
						phase_d         = PH_RDM;
						rdm_sum_d       = 16'(SC_RDM);
						pos_d           = POS_W'(1);
						prev_dmx_d      = 1'b0;
						res_valid       = 1'b1;
						res.packet_kind = KIND_RDM;
						res.byte_valid  = 1'b1;
					end else begin
						phase_d    = PH_IDLE;
						prev_dmx_d = 1'b0;
					end
				end
				PH_DMX: begin
					slot_time_d      = floored;
					pos_d            = pos_inc;
					res_valid        = 1'b1;
					res.packet_kind  = KIND_DMX;
					res.byte_valid   = 1'b1;
					res.slot_time_us = floored;
					if (pos_inc > POS_W'(UNIVERSE_SLOTS)) begin
						phase_d            = PH_IDLE;
						res.packet_event   = EV_GOOD;
						res.dmx_slot_count = SLOT_W'(UNIVERSE_SLOTS);
					end
				end
				PH_RDM: begin
					res_valid       = 1'b1;
					res.packet_kind = KIND_RDM;
					if (pos_q >= POS_W'(RDM_BUFFER_BYTES)) begin
						// buffer full: drop the message
						phase_d          = PH_IDLE;
						res.packet_event = EV_OVERFLOW;
						res.slot_index   = '0;
						res.slot_byte    = '0;
					end else begin
						rdm_sum_d = sum_add;
						if (pos_q == POS_W'(1)) begin
							rdm_sub_d = item.rx_byte;
						end
						if (pos_q == POS_W'(2)) begin
							rdm_len_d = item.rx_byte;
						end
						pos_d = pos_inc;
						// length compare only once the length byte is in
						if (pos_inc >= POS_W'(3) && pos_inc == POS_W'(rdm_len_d)) begin
							phase_d = PH_CSH;
						end
						res.byte_valid = 1'b1;
					end
				end
				PH_CSH: begin
					rdm_sum_d       = rdm_sum_q - {item.rx_byte, 8'h00};
					pos_d           = pos_inc;
					phase_d         = PH_CSL;
					res_valid       = 1'b1;
					res.packet_kind = KIND_RDM;
					res.byte_valid  = 1'b1;
				end
				PH_CSL: begin
					rdm_sum_d       = sum_csl;
					pos_d           = pos_inc;
					phase_d         = PH_IDLE;
					res_valid       = 1'b1;
					res.packet_kind = KIND_RDM;
					res.byte_valid  = 1'b1;
					res.packet_event = (sum_csl == 16'h0000 && rdm_sub_q == RDM_SUB_SC) ?
						EV_GOOD : EV_REJECT;
				end
				PH_DFE: begin
					pos_d = pos_inc;
					if (item.rx_byte == DISC_SEP || pos_inc == POS_W'(PREAMBLE_END)) begin
						phase_d    = PH_EUID;
						disc_cnt_d = '0;
					end
					res_valid       = 1'b1;
					res.packet_kind = KIND_DISC;
					res.byte_valid  = 1'b1;
				end
				PH_EUID: begin
					pos_d      = pos_inc;
					disc_cnt_d = disc_inc;
					if (disc_inc == 5'(EUID_BYTES)) begin
						phase_d    = PH_ECS;
						disc_cnt_d = '0;
					end
					res_valid       = 1'b1;
					res.packet_kind = KIND_DISC;
					res.byte_valid  = 1'b1;
				end
				PH_ECS: begin
					pos_d      = pos_inc;
					disc_cnt_d = disc_inc;
					if (disc_inc == 5'(DISC_CS_BYTES)) begin
						phase_d          = PH_IDLE;
						disc_cnt_d       = '0;
						res.packet_event = EV_GOOD;
					end
					res_valid       = 1'b1;
					res.packet_kind = KIND_DISC;
					res.byte_valid  = 1'b1;
				end
				default: begin
					phase_d    = PH_IDLE;
					prev_dmx_d = 1'b0;
				end
			endcase
		end
	end

	// slot time floor register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_slot_q <= MIN_SLOT_RESET;
		end else if (cfg_wr_en) begin
			min_slot_q <= cfg_wr_data;
		end
	end

	// frame state, updated on each input transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			pos_q        <= '0;
			disc_cnt_q   <= '0;
			rdm_sum_q    <= '0;
			rdm_len_q    <= '0;
			rdm_sub_q    <= '0;
			last_time_q  <= '0;
			slot_time_q  <= '0;
			brk_latest_q <= '0;
			brk_prev_q   <= '0;
			prev_dmx_q   <= 1'b0;
		end else if (fire) begin
			phase_q      <= phase_d;
			pos_q        <= pos_d;
			disc_cnt_q   <= disc_cnt_d;
			rdm_sum_q    <= rdm_sum_d;
			rdm_len_q    <= rdm_len_d;
			rdm_sub_q    <= rdm_sub_d;
			last_time_q  <= last_time_d;
			slot_time_q  <= slot_time_d;
			brk_latest_q <= brk_latest_d;
			brk_prev_q   <= brk_prev_d;
			prev_dmx_q   <= prev_dmx_d;
		end
	end

endmodule

### design/dmxrdm_out_skid.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmxrdm_out_skid
// Result register with one skid entry, so the input side can still take a
// transfer while the output stalls; full rises once the skid entry is used.
// ----------------------------------------------------------------------------
module dmxrdm_out_skid (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  dmxrdm_pkg::out_item_t push_data,
	output logic                  full,
	output logic                  out_valid,
	input  logic                  out_stall,
	output dmxrdm_pkg::out_item_t out_data
);
	import dmxrdm_pkg::*;

	logic      valid_q;
	logic      skid_valid_q;
	out_item_t data_q;
	out_item_t skid_q;

	assign full      = skid_valid_q;
	assign out_valid = valid_q;
	assign out_data  = data_q;

	// valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q      <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!valid_q || !out_stall) begin
			valid_q      <= skid_valid_q | push;
			skid_valid_q <= 1'b0;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (!valid_q || !out_stall) begin
			data_q <= skid_valid_q ? skid_q : push_data;
		end else if (push) begin
			skid_q <= push_data;
		end
	end

endmodule
